// ----- rtl/core/ring_search_nearest_cell_unit_assert.svh -----
// Assertion macros for the ring search RTL.
// Each macro expects aclk and aresetn in the enclosing scope.
`ifndef RING_SEARCH_NEAREST_CELL_UNIT_ASSERT_SVH
`define RING_SEARCH_NEAREST_CELL_UNIT_ASSERT_SVH

// Same-cycle implication.
`define RSCN_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rscn assertion failed");

// Next-cycle implication.
`define RSCN_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rscn assertion failed");

`endif

// ----- rtl/core/rscn_pkg.sv -----
package rscn_pkg;

    localparam int COORD_W     = 11;   // signed ring coordinate, covers -256..511
    localparam int K_W         = 9;    // ring radius, at most RING_MAX
    localparam int DIM_W       = 9;    // grid size, 0..256
    localparam int POS_W       = 8;    // row or column
    localparam int ROAD_W      = 8;
    localparam int PATCH_FLD_W = 16;
    localparam int MUL_W       = 9;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int SQ_W        = 16;
    localparam int DIST_W      = SQ_W + 1;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int EXTRA_W     = 8;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 16;

    localparam logic [K_W-1:0] RING_MAX = K_W'(256);

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_RINGS = 2'd2;

    localparam logic [DIM_W-1:0]   GRID_DIM_RST    = 9'd256;
    localparam logic [EXTRA_W-1:0] EXTRA_RINGS_RST = 8'd20;

    // Road codes that never count as a road cell.
    localparam logic signed [ROAD_W-1:0] ROAD_SKIP_LO  = 8'sd1;
    localparam logic signed [ROAD_W-1:0] ROAD_SKIP_MID = 8'sd2;
    localparam logic signed [ROAD_W-1:0] ROAD_SKIP_HI  = 8'sd7;

    typedef logic signed [COORD_W-1:0] coord_t;

    // Packed so that write_row sits in the lowest bits of tdata.
    typedef struct packed {
        logic [PATCH_FLD_W-1:0]  query_patch;
        logic [POS_W-1:0]        query_col;
        logic [POS_W-1:0]        query_row;
        logic signed [ROAD_W-1:0] write_road;
        logic [PATCH_FLD_W-1:0]  write_patch;
        logic [POS_W-1:0]        write_col;
        logic [POS_W-1:0]        write_row;
    } item_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } result_t;

    function automatic logic road_ok(input logic signed [ROAD_W-1:0] code);
        return (code > 8'sd0) && (code != ROAD_SKIP_LO) && (code != ROAD_SKIP_MID)
            && (code != ROAD_SKIP_HI);
    endfunction

endpackage

// ----- rtl/core/rscn_mul.sv -----
module rscn_mul import rscn_pkg::*; (
    input  logic              aclk,
    input  logic [MUL_W-1:0]  op_a,
    input  logic [MUL_W-1:0]  op_b,
    output logic [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/core/rscn_cell_mem.sv -----
module rscn_cell_mem #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16,
    parameter int DATA_W = 24
) (
    input  logic              aclk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/rscn_ctrl.sv -----
`include "ring_search_nearest_cell_unit_assert.svh"

module rscn_ctrl import rscn_pkg::*; #(
    parameter int ADDR_W  = 16,
    parameter int PATCH_W = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      in_kind,
    input  item_t                     in_item,
    input  logic [DIM_W-1:0]          rows,
    input  logic [DIM_W-1:0]          cols,
    input  logic [EXTRA_W-1:0]        extra,
    input  logic                      out_free,
    output logic                      res_valid,
    output result_t                   result,
    output logic                      mem_we,
    output logic                      mem_re,
    output logic [ADDR_W-1:0]         mem_addr,
    output logic [PATCH_W+ROAD_W-1:0] mem_wdata,
    input  logic [PATCH_W+ROAD_W-1:0] mem_rdata,
    output logic [MUL_W-1:0]          mul_a,
    output logic [MUL_W-1:0]          mul_b,
    input  logic [PROD_W-1:0]         mul_prod
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_WADDR = 4'd1;
    localparam logic [3:0] ST_WR    = 4'd2;
    localparam logic [3:0] ST_SEG   = 4'd3;
    localparam logic [3:0] ST_ADDR  = 4'd4;
    localparam logic [3:0] ST_RD    = 4'd5;
    localparam logic [3:0] ST_CHK   = 4'd6;
    localparam logic [3:0] ST_SQC   = 4'd7;
    localparam logic [3:0] ST_CMP   = 4'd8;
    localparam logic [3:0] ST_RING  = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    logic [3:0]               state_reg, state_next;
    logic [K_W-1:0]           k_reg, k_next;
    logic [1:0]               seg_reg, seg_next;
    coord_t                   var_reg, var_next;
    coord_t                   end_reg, end_next;
    coord_t                   fix_reg, fix_next;
    logic [POS_W-1:0]         r0_reg, r0_next;
    logic [POS_W-1:0]         c0_reg, c0_next;
    logic [PATCH_W-1:0]       patch_reg, patch_next;
    logic [POS_W-1:0]         w_row_reg, w_row_next;
    logic [POS_W-1:0]         w_col_reg, w_col_next;
    logic [PATCH_W-1:0]       w_patch_reg, w_patch_next;
    logic signed [ROAD_W-1:0] w_road_reg, w_road_next;
    logic                     hit_reg, hit_next;
    logic                     had_hit_reg, had_hit_next;
    logic                     any_reg, any_next;
    logic [K_W-1:0]           first_reg, first_next;
    logic [DIST_W-1:0]        best_d_reg, best_d_next;
    logic [POS_W-1:0]         best_r_reg, best_r_next;
    logic [POS_W-1:0]         best_c_reg, best_c_next;
    logic [SQ_W-1:0]          sq_r_reg, sq_r_next;

    coord_t                   r0_s, c0_s, k_s, rows_s, cols_s;
    coord_t                   ctr_fix, ctr_var, fix_c, lo, hi, fix_lim, var_lim;
    coord_t                   start_c, stop_c, i_cur, j_cur;
    logic                     fix_ok;
    logic [POS_W-1:0]         i8, j8, col_sel, dr_abs, dc_abs;
    logic [PATCH_W-1:0]       rd_patch;
    logic signed [ROAD_W-1:0] rd_road;
    logic [DIST_W-1:0]        sq_dist;
    logic [K_W-1:0]           first_new;
    logic [K_W:0]             k_inc, ring_lim;
    logic                     advance, seg_skip;

    // Ring segment geometry: 0 top row, 1 bottom row, 2 left column, 3 right column
    assign r0_s    = coord_t'({3'b000, r0_reg});
    assign c0_s    = coord_t'({3'b000, c0_reg});
    assign k_s     = coord_t'({2'b00, k_reg});
    assign rows_s  = coord_t'({2'b00, rows});
    assign cols_s  = coord_t'({2'b00, cols});
    assign ctr_fix = seg_reg[1] ? c0_s : r0_s;
    assign ctr_var = seg_reg[1] ? r0_s : c0_s;
    assign fix_c   = seg_reg[0] ? ctr_fix + k_s : ctr_fix - k_s;
    assign lo      = ctr_var - k_s;
    assign hi      = ctr_var + k_s;
    assign fix_lim = seg_reg[1] ? cols_s : rows_s;
    assign var_lim = seg_reg[1] ? rows_s : cols_s;
    assign fix_ok  = (fix_c >= 0) && (fix_c < fix_lim);
    assign start_c = (lo < 0) ? '0 : lo;
    assign stop_c  = (hi > var_lim - coord_t'(1)) ? var_lim - coord_t'(1) : hi;

    assign i_cur   = seg_reg[1] ? var_reg : fix_reg;
    assign j_cur   = seg_reg[1] ? fix_reg : var_reg;
    assign i8      = i_cur[POS_W-1:0];
    assign j8      = j_cur[POS_W-1:0];
    assign dr_abs  = (r0_reg >= i8) ? r0_reg - i8 : i8 - r0_reg;
    assign dc_abs  = (c0_reg >= j8) ? c0_reg - j8 : j8 - c0_reg;

    assign rd_patch = mem_rdata[PATCH_W-1:0];
    assign rd_road  = mem_rdata[PATCH_W+ROAD_W-1:PATCH_W];
    assign sq_dist  = {1'b0, sq_r_reg} + {1'b0, mul_prod[SQ_W-1:0]};

    assign first_new = (!had_hit_reg && hit_reg) ? k_reg : first_reg;
    assign k_inc     = {1'b0, k_reg} + 1'b1;
    assign ring_lim  = {1'b0, first_new} + {2'b00, extra};

    assign mem_addr  = ADDR_W'(mul_prod + {{(PROD_W-POS_W){1'b0}}, col_sel});
    assign mem_wdata = {w_road_reg, w_patch_reg};

    assign in_ready      = (state_reg == ST_IDLE);
    assign result.found  = hit_reg;
    assign result.row    = hit_reg ? best_r_reg : '0;
    assign result.col    = hit_reg ? best_c_reg : '0;

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        seg_next     = seg_reg;
        var_next     = var_reg;
        end_next     = end_reg;
        fix_next     = fix_reg;
        r0_next      = r0_reg;
        c0_next      = c0_reg;
        patch_next   = patch_reg;
        w_row_next   = w_row_reg;
        w_col_next   = w_col_reg;
        w_patch_next = w_patch_reg;
        w_road_next  = w_road_reg;
        hit_next     = hit_reg;
        had_hit_next = had_hit_reg;
        any_next     = any_reg;
        first_next   = first_reg;
        best_d_next  = best_d_reg;
        best_r_next  = best_r_reg;
        best_c_next  = best_c_reg;
        sq_r_next    = sq_r_reg;
        advance      = 1'b0;
        seg_skip     = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        res_valid    = 1'b0;
        col_sel      = j8;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if (in_kind) begin
                        r0_next      = in_item.query_row;
                        c0_next      = in_item.query_col;
                        patch_next   = in_item.query_patch[PATCH_W-1:0];
                        k_next       = K_W'(1);
                        seg_next     = 2'd0;
                        hit_next     = 1'b0;
                        had_hit_next = 1'b0;
                        any_next     = 1'b0;
                        first_next   = '0;
                        state_next   = ST_SEG;
                    end else begin
                        w_row_next   = in_item.write_row;
                        w_col_next   = in_item.write_col;
                        w_patch_next = in_item.write_patch[PATCH_W-1:0];
                        w_road_next  = in_item.write_road;
                        state_next   = ST_WADDR;
                    end
                end
            end
            ST_WADDR: begin
                // drop writes outside the grid in use
                if (({1'b0, w_row_reg} < rows) && ({1'b0, w_col_reg} < cols)) begin
                    mul_a      = {1'b0, w_row_reg};
                    mul_b      = cols;
                    state_next = ST_WR;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_WR: begin
                mem_we     = 1'b1;
                col_sel    = w_col_reg;
                state_next = ST_IDLE;
            end
            ST_SEG: begin
                if (fix_ok && (start_c <= stop_c)) begin
                    var_next   = start_c;
                    end_next   = stop_c;
                    fix_next   = fix_c;
                    state_next = ST_ADDR;
                end else begin
                    seg_skip = 1'b1;
                end
            end
            ST_ADDR: begin
                mul_a      = {1'b0, i8};
                mul_b      = cols;
                state_next = ST_RD;
            end
            ST_RD: begin
                mem_re     = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                if (rd_patch == patch_reg) begin
                    any_next = 1'b1;
                    if (road_ok(rd_road)) begin
                        mul_a      = {1'b0, dr_abs};
                        mul_b      = {1'b0, dr_abs};
                        state_next = ST_SQC;
                    end else begin
                        advance = 1'b1;
                    end
                end else begin
                    advance = 1'b1;
                end
            end
            ST_SQC: begin
                sq_r_next  = mul_prod[SQ_W-1:0];
                mul_a      = {1'b0, dc_abs};
                mul_b      = {1'b0, dc_abs};
                state_next = ST_CMP;
            end
            ST_CMP: begin
                // strict compare keeps the first cell on a tie
                if (!hit_reg || (sq_dist < best_d_reg)) begin
                    hit_next    = 1'b1;
                    best_d_next = sq_dist;
                    best_r_next = i8;
                    best_c_next = j8;
                end
                advance = 1'b1;
            end
            ST_RING: begin
                first_next = first_new;
                if (!any_reg) begin
                    state_next = ST_DONE;
                end else if (hit_reg && (k_inc > ring_lim)) begin
                    state_next = ST_DONE;
                end else begin
                    k_next       = k_inc[K_W-1:0];
                    seg_next     = 2'd0;
                    had_hit_next = hit_reg;
                    any_next     = 1'b0;
                    state_next   = ST_SEG;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (advance) begin
            if (var_reg == end_reg) begin
                seg_skip = 1'b1;
            end else begin
                var_next   = var_reg + coord_t'(1);
                state_next = ST_ADDR;
            end
        end

        if (seg_skip) begin
            if (seg_reg == 2'd3) begin
                state_next = ST_RING;
            end else begin
                seg_next   = seg_reg + 2'd1;
                state_next = ST_SEG;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg       <= k_next;
        seg_reg     <= seg_next;
        var_reg     <= var_next;
        end_reg     <= end_next;
        fix_reg     <= fix_next;
        r0_reg      <= r0_next;
        c0_reg      <= c0_next;
        patch_reg   <= patch_next;
        w_row_reg   <= w_row_next;
        w_col_reg   <= w_col_next;
        w_patch_reg <= w_patch_next;
        w_road_reg  <= w_road_next;
        hit_reg     <= hit_next;
        had_hit_reg <= had_hit_next;
        any_reg     <= any_next;
        first_reg   <= first_next;
        best_d_reg  <= best_d_next;
        best_r_reg  <= best_r_next;
        best_c_reg  <= best_c_next;
        sq_r_reg    <= sq_r_next;
    end

    `RSCN_ASSERT_NEXT(a_query_start, in_valid && in_ready && in_kind, (state_reg == ST_SEG) && (k_reg == K_W'(1)))
    `RSCN_ASSERT_NEXT(a_best_shrinks, (state_reg == ST_CMP) && hit_reg, best_d_reg <= $past(best_d_reg))
    `RSCN_ASSERT_NOW(a_found_in_grid, res_valid && result.found, ({1'b0, result.row} < rows) && ({1'b0, result.col} < cols))
    `RSCN_ASSERT_NOW(a_ring_bound, (state_reg == ST_SEG) || (state_reg == ST_RING), (k_reg != '0) && (k_reg <= RING_MAX))

endmodule

// ----- rtl/core/ring_search_nearest_cell_unit.sv -----
// Channel   Dir  Handshake                 Payload
// s_        in   s_tvalid / s_tready       s_tuser kind; s_tdata cell write or query
// m_        out  m_tvalid / m_tready       m_tuser found; m_tdata found position
// cfg_      in   cfg_valid / cfg_ready     cfg_index register, cfg_data value
//
// A cell write: accept, address multiply, memory write. A query is accepted, visits
// each ring segment, steps each in-bounds ring cell through address multiply, memory
// read and check, adds squared row and column offsets and a compare for each cell with
// the sought patch and a usable road code, closes each ring and hands off; the
// single-port memory and shared 9x9 multiplier (address, squared offsets) order them.
// aresetn is synchronous and active low; it clears control state and loads the
// configuration defaults, the cell memory keeps whatever it held.
// s_tready is low while an item is in work; a result waits in the output register
// while the next item is accepted, and a query cannot finish until that register frees.
module ring_search_nearest_cell_unit import rscn_pkg::*; #(
    parameter int MAX_ROWS   = 256,
    parameter int MAX_COLS   = 256,
    parameter int PATCH_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // write_row, write_col, write_patch, write_road, query_row, query_col, query_patch
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,     // kind
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // found_row, found_col
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tuser,     // found
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CELLS   = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int PATCH_W = (PATCH_BITS < PATCH_FLD_W) ? PATCH_BITS : PATCH_FLD_W;
    localparam int MEM_W   = PATCH_W + ROAD_W;

    logic [DIM_W-1:0]   rows_reg, rows_next;
    logic [DIM_W-1:0]   cols_reg, cols_next;
    logic [EXTRA_W-1:0] extra_reg, extra_next;
    logic [DIM_W-1:0]   eff_rows, eff_cols;

    logic               m_valid_reg, m_valid_next;
    result_t            m_res_reg, m_res_next;
    logic               out_free;

    logic               res_valid;
    result_t            result;
    logic               mem_we, mem_re;
    logic [ADDR_W-1:0]  mem_addr;
    logic [MEM_W-1:0]   mem_wdata, mem_rdata;
    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [PROD_W-1:0]  mul_prod;

    // Configuration: always ready, writes beyond the register list are dropped.
    assign cfg_ready = 1'b1;

    always_comb begin
        rows_next  = rows_reg;
        cols_next  = cols_reg;
        extra_next = extra_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_GRID_ROWS:   rows_next  = cfg_data;
                CFG_GRID_COLS:   cols_next  = cfg_data;
                CFG_EXTRA_RINGS: extra_next = cfg_data[EXTRA_W-1:0];
                default:         rows_next  = rows_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg  <= GRID_DIM_RST;
            cols_reg  <= GRID_DIM_RST;
            extra_reg <= EXTRA_RINGS_RST;
        end else begin
            rows_reg  <= rows_next;
            cols_reg  <= cols_next;
            extra_reg <= extra_next;
        end
    end

    // Saturate the grid size to what the memory was built for.
    assign eff_rows = ({4'b0000, rows_reg} > 13'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_reg;
    assign eff_cols = ({4'b0000, cols_reg} > 13'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_reg;

    // Output register: hold the result until the transfer completes.
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
            m_res_next   = result;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.found;
    assign m_tdata  = {m_res_reg.col, m_res_reg.row};

    rscn_ctrl #(
        .ADDR_W  (ADDR_W),
        .PATCH_W (PATCH_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .in_item   (item_t'(s_tdata)),
        .rows      (eff_rows),
        .cols      (eff_cols),
        .extra     (extra_reg),
        .out_free  (out_free),
        .res_valid (res_valid),
        .result    (result),
        .mem_we    (mem_we),
        .mem_re    (mem_re),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata),
        .mul_a     (mul_a),
        .mul_b     (mul_b),
        .mul_prod  (mul_prod)
    );

    rscn_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    rscn_cell_mem #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W),
        .DATA_W (MEM_W)
    ) u_cell_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule
